@@ src/bps_pkg.sv @@
// byte pattern search: shared widths, command and register codes, cell control word
// and the ascii case folding function. No dependencies.
package bps_pkg;

  localparam int BYTE_W = 8;
  localparam int SLOT_W = 8;
  localparam int SLOT_COUNT = 256;
  localparam int LEN_W = 9;
  localparam int CMD_W = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int DEF_MAX_PATTERN = 256;
  localparam int DEF_ADDRESS_BITS = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_CASE = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic              load_en;
    logic              data_en;
    logic              clear;
    logic              kill;
    logic              ignore_case;
    logic [BYTE_W-1:0] data_c;
    logic [BYTE_W-1:0] pattern_byte;
    logic [SLOT_W-1:0] pattern_slot;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic ic);
    logic [BYTE_W-1:0] r;
    r = b;
    if (ic && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ src/bps_cell.sv @@
// byte pattern search: one cell of the match chain, holding one pattern byte and
// one partial match bit, fed by its lower neighbor. Depends on bps_pkg.
module bps_cell #(
  parameter int INDEX = 0,
  parameter int MAX_PATTERN = bps_pkg::DEF_MAX_PATTERN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bps_pkg::cell_ctrl_t            ctrl,
  input  logic [$clog2(MAX_PATTERN)-1:0] last_idx,
  input  logic                           prev_bit,
  output logic                           match_bit
);
  import bps_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATTERN);

  logic [BYTE_W-1:0] pattern;
  logic              slot_hit;
  logic              active;
  logic              prev_ok;
  logic              hit;

  always_comb begin
    slot_hit = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if ((s % MAX_PATTERN) == INDEX && ctrl.pattern_slot == SLOT_W'(s)) begin
        slot_hit = 1'b1;
      end
    end
  end

  assign active = IDX_W'(INDEX) <= last_idx;
  assign prev_ok = (INDEX == 0) ? 1'b1 : (prev_bit && !ctrl.kill);
  assign hit = active && prev_ok && (fold_byte(pattern, ctrl.ignore_case) == ctrl.data_c);

  always_ff @(posedge clk) begin
    if (ctrl.load_en && slot_hit) begin
      pattern <= ctrl.pattern_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else if (ctrl.data_en) begin
      match_bit <= hit;
    end else if (ctrl.clear || ctrl.kill) begin
      match_bit <= 1'b0;
    end
  end

endmodule

@@ src/byte_pattern_search_unit.sv @@
// byte pattern search: top level with apb registers, the row of match cells,
// the match stage and the output register. Depends on bps_pkg and bps_cell.
//
// Usage: pattern bytes are loaded with cmd load words (pattern_slot, pattern_byte),
// then the memory stream is sent as cmd data words (data_byte, byte_address,
// present). A restart word clears any partial match. Every input word yields
// exactly one result word; found is set on the data word that completes a match,
// with match_address holding the start address, else match_address is zero.
// Matches never overlap. An absent byte drops any partial match.
// Registers: pattern_length at 0x0 (1..MAX_PATTERN), ignore_case at 0x4; write
// them only while no word is in flight.
// Results pass through the match stage and the output register. Throughput is one
// word per cycle unless stalled, as the cell row updates all partial bits at once.
// When result_ready is low, the output register and the match stage hold and
// item_ready drops once both are full; nothing is lost.
// Reset: partial bits and pipeline valids clear, pattern_length resets to 1,
// ignore_case to 0; pattern bytes are undefined until loaded.
module byte_pattern_search_unit #(
  parameter int MAX_PATTERN = bps_pkg::DEF_MAX_PATTERN,
  parameter int ADDRESS_BITS = bps_pkg::DEF_ADDRESS_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bps_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [bps_pkg::CMD_W-1:0]      cmd,
  input  logic [bps_pkg::SLOT_W-1:0]     pattern_slot,
  input  logic [bps_pkg::BYTE_W-1:0]     pattern_byte,
  input  logic [bps_pkg::BYTE_W-1:0]     data_byte,
  input  logic [ADDRESS_BITS-1:0]        byte_address,
  input  logic                           present,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           found,
  output logic [ADDRESS_BITS-1:0]        match_address
);
  import bps_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATTERN);

  logic [LEN_W-1:0]        pattern_length;
  logic                    ignore_case;
  logic [IDX_W-1:0]        last_idx;

  logic                    accept;
  logic                    data_en;
  logic                    clear_en;
  logic                    kill;
  cell_ctrl_t              ctrl;
  logic [MAX_PATTERN-1:0]  bits;

  logic                    a_valid;
  logic                    a_data;
  logic [ADDRESS_BITS-1:0] a_addr;
  logic                    a_move;
  logic                    found_a;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      ignore_case <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        REG_CASE:   ignore_case <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LENGTH: prdata = APB_DATA_W'(pattern_length);
      REG_CASE:   prdata = APB_DATA_W'(ignore_case);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (pattern_length == '0) begin
      last_idx = '0;
    end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
      last_idx = IDX_W'(MAX_PATTERN - 1);
    end else begin
      last_idx = IDX_W'(32'(pattern_length) - 32'd1);
    end
  end

  // handshake and cell control
  assign found_a = a_data && bits[last_idx];
  assign a_move = a_valid && (!result_valid || result_ready);
  assign item_ready = !a_valid || a_move;
  assign accept = item_valid && item_ready;
  assign data_en = accept && cmd == CMD_DATA && present;
  assign clear_en = accept && (cmd == CMD_RESTART || (cmd == CMD_DATA && !present));
  assign kill = a_move && found_a;

  always_comb begin
    ctrl.load_en = accept && cmd == CMD_LOAD;
    ctrl.data_en = data_en;
    ctrl.clear = clear_en;
    ctrl.kill = kill;
    ctrl.ignore_case = ignore_case;
    ctrl.data_c = fold_byte(data_byte, ignore_case);
    ctrl.pattern_byte = pattern_byte;
    ctrl.pattern_slot = pattern_slot;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev_bit;
    if (i == 0) begin : g_first
      assign prev_bit = 1'b1;
    end else begin : g_rest
      assign prev_bit = bits[i-1];
    end
    bps_cell #(
      .INDEX(i),
      .MAX_PATTERN(MAX_PATTERN)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .last_idx(last_idx),
      .prev_bit(prev_bit),
      .match_bit(bits[i])
    );
  end

  // match stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data <= data_en;
      a_addr <= byte_address - ADDRESS_BITS'(last_idx);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      found <= found_a;
      match_address <= found_a ? a_addr : '0;
    end
  end

  a_no_addr_without_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_address == '0)
    else $error("match_address set without a match");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid && !a_valid)
    else $error("pipeline not empty after reset");

  a_match_clears: assert property (@(posedge clk) disable iff (rst)
    kill && !data_en |=> bits == '0)
    else $error("partial bits survive a reported match");

  a_clear_cmd: assert property (@(posedge clk) disable iff (rst)
    clear_en |=> bits == '0)
    else $error("partial bits survive restart or absent byte");

endmodule

@@ tb/bps_scoreboard.sv @@
`timescale 1ns / 100ps
// byte pattern search testbench: word and report types and the search scoreboard,
// which predicts every report from its own pattern store and partial-match bits.
// Depends on bps_pkg.
package bps_tb_pkg;
  import bps_pkg::*;

  localparam int ADDR_W = DEF_ADDRESS_BITS;
  localparam int SLOTS = DEF_MAX_PATTERN;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] pbyte;
    logic [BYTE_W-1:0] dbyte;
    logic [ADDR_W-1:0] addr;
    logic              present;
  } search_word_t;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } match_report_t;

  class search_scoreboard;
    logic [BYTE_W-1:0] pattern_mem [SLOTS];
    bit                partial_bits [SLOTS];
    logic [LEN_W-1:0]  length_reg;
    logic              fold_en;
    match_report_t     owed_reports [$];
    int                errors;
    int                checked;
    int                match_count;

    function new();
      foreach (pattern_mem[i]) pattern_mem[i] = '0;
      clear_partials();
      length_reg = LEN_W'(1);
      fold_en = 1'b0;
      errors = 0;
      checked = 0;
      match_count = 0;
    endfunction

    function void clear_partials();
      foreach (partial_bits[i]) partial_bits[i] = 1'b0;
    endfunction

    function int active_len();
      if (length_reg == 0) return 1;
      if (length_reg > SLOTS) return SLOTS;
      return int'(length_reg);
    endfunction

    function logic [BYTE_W-1:0] fold_letter(logic [BYTE_W-1:0] b);
      if (fold_en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + CASE_OFFSET;
      return b;
    endfunction

    function void write_reg(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_LENGTH) begin
        length_reg = value[LEN_W-1:0];
      end else begin
        fold_en = value[0];
      end
    endfunction

    function void note_word(search_word_t w);
      match_report_t r;
      int len;
      int i;
      logic [BYTE_W-1:0] c;
      r.found = 1'b0;
      r.addr = '0;
      case (w.cmd)
        CMD_LOAD: pattern_mem[w.slot] = w.pbyte;
        CMD_RESTART: clear_partials();
        CMD_DATA: begin
          if (!w.present) begin
            clear_partials();
          end else begin
            len = active_len();
            c = fold_letter(w.dbyte);
            // top down so each cell sees the old bit below it
            for (i = SLOTS - 1; i >= 0; i--) begin
              partial_bits[i] = (i < len) && (fold_letter(pattern_mem[i]) == c) &&
                                (i == 0 || partial_bits[i-1]);
            end
            if (partial_bits[len-1]) begin
              r.found = 1'b1;
              r.addr = w.addr - ADDR_W'(len - 1);
              match_count++;
              clear_partials();
            end
          end
        end
        default: ;
      endcase
      owed_reports.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task check_report(logic found, logic [ADDR_W-1:0] addr);
      match_report_t e;
      if (owed_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected word found=%0b address=%h", found, addr));
        return;
      end
      e = owed_reports.pop_front();
      checked++;
      if (found !== e.found) begin
        report_mismatch($sformatf("word %0d found=%0b, want %0b", checked, found, e.found));
      end
      if (addr !== e.addr) begin
        report_mismatch($sformatf("word %0d match_address=%h, want %h", checked, addr, e.addr));
      end
    endtask
  endclass

endpackage

@@ tb/byte_pattern_search_unit_tb.sv @@
`timescale 1ns / 100ps
// byte pattern search testbench top: clock, reset, apb register writes, word driver
// with random gaps, randomly stalling result sink and the end-of-run verdict.
// Depends on bps_pkg, bps_tb_pkg and byte_pattern_search_unit.
module byte_pattern_search_unit_tb;
  import bps_pkg::*;
  import bps_tb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_WORDS = 400;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid;
  logic                  item_ready;
  logic [CMD_W-1:0]      cmd;
  logic [SLOT_W-1:0]     pattern_slot;
  logic [BYTE_W-1:0]     pattern_byte;
  logic [BYTE_W-1:0]     data_byte;
  logic [ADDR_W-1:0]     byte_address;
  logic                  present;
  logic                  result_valid;
  logic                  result_ready;
  logic                  found;
  logic [ADDR_W-1:0]     match_address;

  search_scoreboard sb;
  int cycles = 0;
  int words_sent = 0;
  bit sender_gaps = 1'b0;

  byte_pattern_search_unit dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_report(found, match_address);
  end

  initial begin : result_sink
    int mode;
    int span;
    int k;
    result_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 99);
      span = (mode < 40) ? $urandom_range(5, 40) :
             (mode < 90) ? $urandom_range(5, 30) : $urandom_range(20, 60);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (mode < 40) begin
          result_ready <= 1'b1;
        end else if (mode < 90) begin
          result_ready <= 1'($urandom_range(0, 1));
        end else begin
          result_ready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!sender_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] swap_case(logic [BYTE_W-1:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + CASE_OFFSET;
    if (b >= CHAR_UPPER_A + CASE_OFFSET && b <= CHAR_UPPER_Z + CASE_OFFSET) begin
      return b - CASE_OFFSET;
    end
    return b;
  endfunction

  // small alphabet so patterns recur, plus the folding boundaries
  function automatic logic [BYTE_W-1:0] rand_char();
    case ($urandom_range(0, 11))
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "B";
      4: return 8'h40;
      5: return 8'h5B;
      6: return 8'h60;
      7: return 8'h7B;
      8: return "Z";
      9: return "z";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int small_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r < 8) return $urandom_range(2, 6);
    return $urandom_range(7, 24);
  endfunction

  task automatic send_word(search_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= w.cmd;
    pattern_slot <= w.slot;
    pattern_byte <= w.pbyte;
    data_byte <= w.dbyte;
    byte_address <= w.addr;
    present <= w.present;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_word(w);
    if (w.cmd != CMD_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(logic [SLOT_W-1:0] slot, logic [BYTE_W-1:0] b);
    send_word(search_word_t'{CMD_LOAD, slot, b, 8'($urandom), ADDR_W'($urandom),
                             1'($urandom)});
  endtask

  task automatic send_data(logic [BYTE_W-1:0] b, logic [ADDR_W-1:0] a, logic p);
    send_word(search_word_t'{CMD_DATA, 8'($urandom), 8'($urandom), b, a, p});
  endtask

  task automatic send_ctrl(logic [CMD_W-1:0] c);
    send_word(search_word_t'{c, 8'($urandom), 8'($urandom), 8'($urandom),
                             ADDR_W'($urandom), 1'($urandom)});
  endtask

  task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int len, logic fold);
    if ($urandom_range(0, 1)) begin
      apb_write(REG_LENGTH, APB_DATA_W'(len));
      apb_write(REG_CASE, APB_DATA_W'(fold));
    end else begin
      apb_write(REG_CASE, APB_DATA_W'(fold));
      apb_write(REG_LENGTH, APB_DATA_W'(len));
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (sb.owed_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic directed_checks();
    sender_gaps = 1'b0;
    send_load(8'd0, "a");
    send_load(8'd255, 8'hFF);
    send_data("a", 32'h0, 1'b1);
    send_data("A", 32'h1, 1'b1);
    send_ctrl(CMD_UNUSED);
    send_ctrl(CMD_RESTART);
    send_load(8'd0, 8'h00);
    send_data(8'h00, 32'hFFFF_FFFF, 1'b1);
    settle();
    configure(3, 1'b1);
    send_load(8'd0, "A");
    send_load(8'd1, 8'h40);
    send_load(8'd2, "z");
    // match start wraps below zero
    send_data("a", 32'hFFFF_FFFF, 1'b1);
    send_data(8'h40, 32'h0, 1'b1);
    send_data("Z", 32'h1, 1'b1);
    // absent gap drops the partial match
    send_data("a", 32'h5, 1'b1);
    send_data(8'h40, 32'h6, 1'b1);
    send_data(8'h40, 32'h7, 1'b0);
    send_data("z", 32'h8, 1'b1);
    send_data("a", 32'h9, 1'b1);
    send_ctrl(CMD_RESTART);
    send_data(8'h40, 32'hA, 1'b1);
    send_data("z", 32'hB, 1'b1);
    // partial left open across a length change
    send_data("a", 32'h14, 1'b1);
    send_data(8'h40, 32'h15, 1'b1);
    settle();
    configure(0, 1'b0);
    send_data("A", 32'h16, 1'b1);
    send_data("a", 32'h17, 1'b1);
  endtask

  task automatic run_phase(int len_cfg, logic fold, int data_words, bit reload);
    int eff;
    int sent;
    int pick;
    int k;
    int j;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] b;
    eff = (len_cfg == 0) ? 1 : (len_cfg > SLOTS) ? SLOTS : len_cfg;
    settle();
    configure(len_cfg, fold);
    sender_gaps = ($urandom_range(0, 3) != 0);
    if (reload) begin
      for (k = 0; k < eff; k++) send_load(SLOT_W'(k), rand_char());
    end
    case ($urandom_range(0, 3))
      0: a = ADDR_W'($urandom_range(0, 3));
      1: a = '1 - ADDR_W'($urandom_range(0, 3));
      default: a = ADDR_W'($urandom);
    endcase
    sent = 0;
    while (sent < data_words) begin
      pick = (eff > 32 && sent == 0) ? 0 : $urandom_range(0, 99);
      if (pick < 45) begin
        k = (pick < 34 || eff == 1) ? eff : $urandom_range(1, eff - 1);
        for (j = 0; j < k; j++) begin
          b = sb.pattern_mem[j];
          if (fold ? ($urandom_range(0, 2) == 0) : (eff <= 8 && $urandom_range(0, 7) == 0)) begin
            b = swap_case(b);
          end
          send_data(b, a, 1'b1);
          a++;
          sent++;
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) begin
          send_data(rand_char(), a, 1'b1);
          a++;
          sent++;
        end
      end else if (pick < 83) begin
        send_data(8'($urandom), a, 1'b0);
        a++;
        sent++;
      end else if (pick < 88) begin
        send_ctrl(CMD_RESTART);
        sent++;
      end else if (pick < 92) begin
        send_ctrl(CMD_UNUSED);
      end else if (pick < 96) begin
        send_load(SLOT_W'($urandom_range(0, eff - 1)), rand_char());
        sent++;
      end else begin
        a = ADDR_W'($urandom);
      end
    end
  endtask

  initial begin
    int phase;
    int directed_words;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    cmd = CMD_LOAD;
    pattern_slot = '0;
    pattern_byte = '0;
    data_byte = '0;
    byte_address = '0;
    present = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    directed_words = words_sent;
    phase = 0;
    while (phase < 3 || words_sent - directed_words < RANDOM_WORDS) begin
      case (phase)
        2: run_phase(511, 1'b1, 256, 1'b1);
        default: run_phase(small_len(), 1'($urandom_range(0, 1)), $urandom_range(30, 60), 1'b1);
      endcase
      phase++;
    end
    settle();

    $display("%0d words over %0d register settings, lengths 0 to 511, both case modes",
             words_sent, phase + 3);
    $display("%0d result words checked, %0d matches predicted, %0d mismatches",
             sb.checked, sb.match_count, sb.errors);
    if (sb.errors == 0 && sb.owed_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bps_pkg.sv
src/bps_cell.sv
src/byte_pattern_search_unit.sv
tb/bps_scoreboard.sv
tb/byte_pattern_search_unit_tb.sv
